@@ rtl/ffba_pkg.sv @@
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_ZERO      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    // Allocation granule; rounding is a shift, so this stays a power of two
    localparam int ALIGN_BYTES = 16;

    typedef struct packed {
        logic        func;
        logic [31:0] request_bytes;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
    } rsp_t;

    // One table entry: data address and size.
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
    } entry_t;

endpackage

@@ rtl/ffba_table.sv @@
// Block table memory: one write port, one read port, registered read data.
module ffba_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ffba_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output ffba_pkg::entry_t rdata
);
    import ffba_pkg::*;

    entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/first_fit_block_allocator_unit.sv @@
// Top level of the first-fit block allocator.
// Usage: pulse start with req while busy is low; the item is taken at that
// edge. busy stays high until the result is shown on rsp for one cycle with
// done high; the receiver cannot stall it. The table lives in one memory
// with one read and one write port, and the scan reads one entry per cycle.
// An allocate scans the entries in order for the first gap, then shifts the
// later entries up one slot and inserts the new one; a free scans for the
// address and shifts any later entries down. Zero requests and a full table
// are answered without a scan. Shifting an entry passes through a read state
// and a write state on the single memory port pair.
// Configuration: cfg_we, cfg_index, cfg_data write heap_base (index 0) or
// heap_limit (index 1) at once, and either write empties the table (the
// live count goes to zero; no memory sweep is needed). Reset clears both
// registers and the live count; the block is ready in the first cycle
// after reset.
module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ffba_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output ffba_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_data
);
    import ffba_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AB = $clog2(ALIGN_BYTES);
    localparam logic [33:0] HDR   = 34'(HEADER_BYTES);
    localparam logic [33:0] HDR2  = 34'(2 * HEADER_BYTES);
    localparam logic [33:0] ALM1  = 34'(ALIGN_BYTES - 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD     = 8'b0000_0010,
        S_CHK    = 8'b0000_0100,
        S_SH_RD  = 8'b0000_1000,
        S_SH_WR  = 8'b0001_0000,
        S_INS    = 8'b0010_0000,
        S_RESP   = 8'b0100_0000,
        S_WAIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] base_reg, limit_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;   // scan index
    logic [CW-1:0] sh_reg, sh_next;     // shift cursor
    logic func_reg;
    logic [33:0] size_reg;
    logic [31:0] addr_reg;
    logic [33:0] prev_reg, prev_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] ga_reg, ga_next;
    logic done_reg, done_next;
    logic func_next;
    logic [33:0] size_next;
    logic [31:0] addr_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    entry_t          wdata, rdata;

    ffba_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [33:0] rnd;
    logic [33:0] next_bound, need;
    logic        at_end;

    // Round request up to the alignment
    assign rnd = ((34'(req.request_bytes) + ALM1) >> AB) << AB;
    assign at_end     = (idx_reg == count_reg);
    assign next_bound = at_end ? 34'(limit_reg) : 34'(rdata.addr);
    assign need       = prev_reg + HDR2 + size_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp.status = st_reg;
    assign rsp.granted_address = ga_reg;

    // Control and datapath
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        sh_next    = sh_reg;
        prev_next  = prev_reg;
        st_next    = st_reg;
        ga_next    = ga_reg;
        done_next  = 1'b0;
        func_next  = func_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        we    = 1'b0;
        waddr = sh_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = req.func;
                    size_next = rnd;
                    addr_next = req.block_address;
                    prev_next = 34'(base_reg);
                    idx_next  = '0;
                    st_next   = ST_OK;
                    ga_next   = '0;
                    raddr     = '0;
                    if (req.func == FUNC_ALLOC && req.request_bytes == '0)
                    begin
                        st_next    = ST_ZERO;
                        state_next = S_RESP;
                    end
                    else if (req.func == FUNC_ALLOC && count_reg >= MAXC)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // rdata holds entry idx_reg (meaningless when at the end)
                if (func_reg == FUNC_ALLOC)
                begin
                    if (next_bound >= need)
                    begin
                        ga_next = prev_reg[31:0] + HDR[31:0];
                        sh_next = count_reg;
                        state_next = (count_reg == idx_reg) ? S_INS : S_SH_RD;
                    end
                    else if (at_end)
                    begin
                        st_next    = ST_NO_SPACE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        prev_next  = 34'(rdata.addr) + 34'(rdata.size);
                        idx_next   = idx_reg + 1'b1;
                        raddr      = AW'(idx_reg + 1'b1);
                        state_next = S_CHK;
                    end
                end
                else
                begin
                    if (at_end)
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_RESP;
                    end
                    else if (rdata.addr == addr_reg)
                    begin
                        sh_next = idx_reg;
                        if (idx_reg + 1'b1 == count_reg)
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SH_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        raddr      = AW'(idx_reg + 1'b1);
                        state_next = S_CHK;
                    end
                end
            end
            S_SH_RD:
            begin
                // read the neighbor that moves into slot sh_reg
                raddr = (func_reg == FUNC_ALLOC) ? AW'(sh_reg - 1'b1) : AW'(sh_reg + 1'b1);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                we    = 1'b1;
                wdata = rdata;
                if (func_reg == FUNC_ALLOC)
                begin
                    sh_next = sh_reg - 1'b1;
                    state_next = (sh_reg - 1'b1 == idx_reg) ? S_INS : S_SH_RD;
                end
                else
                begin
                    sh_next = sh_reg + 1'b1;
                    if (sh_reg + 2'd2 == count_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
            end
            S_INS:
            begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0];
                wdata.addr = ga_reg;
                wdata.size = size_reg[31:0];
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done_next  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            count_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            base_reg  <= '0;
            limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we && cfg_index == REG_HEAP_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HEAP_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sh_reg   <= sh_next;
        prev_reg <= prev_next;
        st_reg   <= st_next;
        ga_reg   <= ga_next;
        func_reg <= func_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
    end

endmodule

@@ rtl/ffba_checker.sv @@
// Port-level checker for the allocator and its bind.
module ffba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input ffba_pkg::rsp_t rsp
);
    import ffba_pkg::*;

    // accepted item makes the block busy next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item not taken");
    // result only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");
    // one result cycle per item
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("repeated result");
    // address only on a successful result
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.granted_address == '0)
        else $error("address on failure");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
